[hw/rtl/ddpc_pkg.sv]
`timescale 1ns / 1ps
package ddpc_pkg;

	localparam int WORD_BITS  = 64;
	localparam int RADIX_BITS = 8;
	// quotient bits resolved per division cycle
	localparam int DIV_BITS   = 8;
	localparam int CHUNKS     = WORD_BITS / DIV_BITS;
	localparam int CHUNK_W    = $clog2(CHUNKS);

	localparam int STEP_W = 3;
	localparam int OP_W   = 3;
	localparam int COND_W = 3;

	typedef logic [STEP_W-1:0] step_t;
	typedef logic [OP_W-1:0]   op_t;
	typedef logic [COND_W-1:0] cond_t;

	// program steps
	localparam step_t STEP_WAIT       = 3'd0;
	localparam step_t STEP_CHECK      = 3'd1;
	localparam step_t STEP_DIV        = 3'd2;
	localparam step_t STEP_DIGIT      = 3'd3;
	localparam step_t STEP_EMIT       = 3'd4;
	localparam step_t STEP_EMIT_RETRY = 3'd5;
	localparam step_t STEP_ZERO       = 3'd6;
	localparam step_t STEP_ZERO_RETRY = 3'd7;

	// datapath operations
	localparam op_t OP_NONE      = 3'd0;
	localparam op_t OP_LOAD      = 3'd1;
	localparam op_t OP_DIV       = 3'd2;
	localparam op_t OP_DIGIT     = 3'd3;
	localparam op_t OP_EMIT      = 3'd4;
	localparam op_t OP_EMIT_ZERO = 3'd5;

	// jump conditions
	localparam cond_t COND_ALWAYS      = 3'd0;
	localparam cond_t COND_NO_WORD     = 3'd1;
	localparam cond_t COND_BOUND_ZERO  = 3'd2;
	localparam cond_t COND_DIV_MORE    = 3'd3;
	localparam cond_t COND_DIGITS_LEFT = 3'd4;
	localparam cond_t COND_OUT_FREE    = 3'd5;

	typedef struct packed {
		op_t   op;
		cond_t cond;
		step_t target;
	} ucode_t;

	typedef struct packed {
		logic word_valid;
		logic bound_zero;
		logic div_more;
		logic digits_left;
		logic out_free;
	} status_t;

	// control store: jump to target when cond holds, else fall through
	function automatic ucode_t ucode_rom(step_t step);
		ucode_t w;
		case (step)
			STEP_WAIT:       w = '{OP_LOAD,      COND_NO_WORD,     STEP_WAIT};
			STEP_CHECK:      w = '{OP_NONE,      COND_BOUND_ZERO,  STEP_ZERO};
			STEP_DIV:        w = '{OP_DIV,       COND_DIV_MORE,    STEP_DIV};
			STEP_DIGIT:      w = '{OP_DIGIT,     COND_DIGITS_LEFT, STEP_DIV};
			STEP_EMIT:       w = '{OP_EMIT,      COND_OUT_FREE,    STEP_WAIT};
			STEP_EMIT_RETRY: w = '{OP_NONE,      COND_ALWAYS,      STEP_EMIT};
			STEP_ZERO:       w = '{OP_EMIT_ZERO, COND_OUT_FREE,    STEP_WAIT};
			STEP_ZERO_RETRY: w = '{OP_NONE,      COND_ALWAYS,      STEP_ZERO};
			default:         w = '{OP_NONE,      COND_ALWAYS,      STEP_WAIT};
		endcase
		return w;
	endfunction

endpackage

[hw/rtl/ddpc_seq.sv]
`timescale 1ns / 1ps
module ddpc_seq import ddpc_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  status_t status,
	output op_t     op,
	output step_t   step
);

	step_t  step_q;
	ucode_t uw;
	logic   take;

	assign uw = ucode_rom(step_q);

	always_comb begin
		case (uw.cond)
			COND_ALWAYS:      take = 1'b1;
			COND_NO_WORD:     take = !status.word_valid;
			COND_BOUND_ZERO:  take = status.bound_zero;
			COND_DIV_MORE:    take = status.div_more;
			COND_DIGITS_LEFT: take = status.digits_left;
			COND_OUT_FREE:    take = status.out_free;
			default:          take = 1'b1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= STEP_WAIT;
		end else begin
			step_q <= take ? uw.target : step_q + STEP_W'(1);
		end
	end

	assign op   = uw.op;
	assign step = step_q;

endmodule

[hw/rtl/ddpc_dp.sv]
`timescale 1ns / 1ps
module ddpc_dp import ddpc_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  op_t                     op,
	output status_t                 status,
	input  logic                    cfg_we,
	input  logic [RADIX_BITS-1:0]   cfg_wdata,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic [2*WORD_BITS-1:0]  in_data,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic [2*WORD_BITS-1:0]  out_data
);

	logic [RADIX_BITS-1:0] radix_q;
	logic [RADIX_BITS-1:0] rdx;
	logic [CHUNK_W-1:0]    chunk_q;
	logic                  out_valid_q;
	logic [2*WORD_BITS-1:0] out_data_q;

	logic [WORD_BITS-1:0]  m_q, y_q, n_q, f_q, w_q;
	logic [RADIX_BITS-1:0] rm_q, ry_q;

	logic [RADIX_BITS+WORD_BITS-1:0] m_div, y_div;
	logic [RADIX_BITS:0]             mp1;
	logic [WORD_BITS+RADIX_BITS:0]   w_prod;
	logic [WORD_BITS+RADIX_BITS-1:0] y_prod;
	logic [WORD_BITS-1:0]            f_next;
	logic                            accept, out_free;

	// DIV_BITS steps of restoring division; returns {remainder, shifted value}
	function automatic logic [RADIX_BITS+WORD_BITS-1:0] div_chunk(
		input logic [RADIX_BITS-1:0] rem,
		input logic [WORD_BITS-1:0]  val,
		input logic [RADIX_BITS-1:0] d
	);
		logic [RADIX_BITS:0]   trial;
		logic [RADIX_BITS-1:0] r;
		logic [WORD_BITS-1:0]  v;
		r = rem;
		v = val;
		for (int i = 0; i < DIV_BITS; i++) begin
			trial = {r, v[WORD_BITS-1]};
			v = {v[WORD_BITS-2:0], 1'b0};
			if (trial >= {1'b0, d}) begin
				r = RADIX_BITS'(trial - {1'b0, d});
				v[0] = 1'b1;
			end else begin
				r = trial[RADIX_BITS-1:0];
			end
		end
		return {r, v};
	endfunction

	// radix of 0 or 1 counts as 2
	assign rdx = (radix_q < RADIX_BITS'(2)) ? RADIX_BITS'(2) : radix_q;

	assign m_div = div_chunk(rm_q, m_q, rdx);
	assign y_div = div_chunk(ry_q, y_q, rdx);

	// digit step, LSB first: a digit above the dominator's replaces the running count
	assign mp1    = {1'b0, rm_q} + (RADIX_BITS+1)'(1);
	assign w_prod = w_q * mp1;
	assign y_prod = w_q * ry_q;
	assign f_next = (ry_q > rm_q) ? w_prod[WORD_BITS-1:0] : f_q + y_prod[WORD_BITS-1:0];

	assign in_ready = (op == OP_LOAD);
	assign accept   = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radix_q     <= RADIX_BITS'(2);
			chunk_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we)
				radix_q <= cfg_wdata;
			if (accept)
				chunk_q <= '0;
			else if (op == OP_DIV)
				chunk_q <= chunk_q + CHUNK_W'(1);
			if ((op == OP_EMIT || op == OP_EMIT_ZERO) && out_free)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		case (op)
			OP_LOAD: begin
				if (accept) begin
					m_q  <= in_data[WORD_BITS-1:0];
					n_q  <= in_data[2*WORD_BITS-1:WORD_BITS];
					y_q  <= in_data[2*WORD_BITS-1:WORD_BITS] - WORD_BITS'(1);
					rm_q <= '0;
					ry_q <= '0;
					f_q  <= WORD_BITS'(1);
					w_q  <= WORD_BITS'(1);
				end
			end
			OP_DIV: begin
				{rm_q, m_q} <= m_div;
				{ry_q, y_q} <= y_div;
			end
			OP_DIGIT: begin
				f_q  <= f_next;
				w_q  <= w_prod[WORD_BITS-1:0];
				rm_q <= '0;
				ry_q <= '0;
			end
			OP_EMIT: begin
				if (out_free)
					out_data_q <= {f_q, n_q - f_q};
			end
			OP_EMIT_ZERO: begin
				if (out_free)
					out_data_q <= '0;
			end
			default: begin
			end
		endcase
	end

	assign status.word_valid  = in_valid;
	assign status.bound_zero  = (n_q == '0);
	assign status.div_more    = (chunk_q != CHUNK_W'(CHUNKS - 1));
	assign status.digits_left = (m_q != '0) || (y_q != '0);
	assign status.out_free    = out_free;

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule

[hw/rtl/digit_dominance_prefix_count_unit.sv]
`timescale 1ns / 1ps
// Digit-dominance prefix count. For each input word (dominator m, bound n) the unit
// counts the values x below n whose every digit in the configured radix is at most
// the matching digit of m (miss_count) and the rest (hit_count = n - miss_count).
// For a prime radix p these are the counts of k < n with C(m,k) nonzero / zero mod p.
// A bound of zero gives two zero counts. A radix of 0 or 1 is treated as 2. The radix
// is to be written by the user through cfg_we / cfg_wdata only while the unit is idle;
// the unit itself does not enforce this. The radix resets to 2. One word is handled
// at a time. After the input word is taken, each radix digit costs a pass of the two
// 8-bit-per-cycle restoring dividers that split off the low digit of m and n-1, plus
// one multiply-accumulate step of the digit DP, until all D digits of the larger of m
// and n-1 are used and the result is registered (D is 64 for radix 2 and all-ones
// operands). A zero bound skips the digit walk. The next word is taken as soon as
// the result sits in the output register, even if the downstream side has not taken
// it yet. Control is a small microprogram: a step counter reads a control word
// from a read-only table, which drives the datapath and picks a conditional jump.
module digit_dominance_prefix_count_unit import ddpc_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [RADIX_BITS-1:0]  cfg_wdata,      // radix
	input  logic                   s_axis_tvalid,
	output logic                   s_axis_tready,
	input  logic [2*WORD_BITS-1:0] s_axis_tdata,   // [63:0] dominator, [127:64] bound
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	output logic [2*WORD_BITS-1:0] m_axis_tdata    // [63:0] hit_count, [127:64] miss_count
);

	status_t status;
	op_t     op;
	step_t   step;

	// microprogram sequencer
	ddpc_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.status (status),
		.op     (op),
		.step   (step)
	);

	// divider, digit DP and output register
	ddpc_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.op        (op),
		.status    (status),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_data   (s_axis_tdata),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_data  (m_axis_tdata)
	);

`ifndef SYNTHESIS
	// a taken word starts the program
	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready) |=> (step == STEP_CHECK))
		else $error("accepted word did not start the program");

	// the program only starts from a taken word
	a_start_needs_word: assert property (@(posedge clk) disable iff (!arst_n)
		(step == STEP_CHECK) |-> $past(s_axis_tvalid && s_axis_tready))
		else $error("program started without an input word");

	// a result appears only from an emit step
	a_result_from_emit: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> ($past(step) == STEP_EMIT || $past(step) == STEP_ZERO))
		else $error("result word not produced by an emit step");
`endif

endmodule

[tb/digit_dominance_prefix_count_unit_tb.sv]
`timescale 1ns / 1ps
module digit_dominance_prefix_count_unit_tb;
	import ddpc_pkg::*;

	// Slowest legal run: about 625 words of 64 digits, plus a long source gap and a long
	// sink stall per word, stays under CYCLE_LIMIT.
	localparam int unsigned CYCLE_LIMIT  = 2_000_000;
	// Wait at least as long as a word of 64 radix-2 digits needs after the last result.
	localparam int          DRAIN_CYCLES = 600;
	localparam int          PHASE_WORDS  = 50;
	localparam int          MAX_REPORTS  = 100;

	typedef logic [WORD_BITS-1:0] word_t;

	typedef struct packed {
		word_t hit;
		word_t miss;
	} count_pair_t;

	logic                   clk           = 1'b0;
	logic                   arst_n        = 1'b0;
	logic                   cfg_we        = 1'b0;
	logic [RADIX_BITS-1:0]  cfg_wdata     = '0;      // radix
	logic                   s_axis_tvalid = 1'b0;
	logic                   s_axis_tready;
	logic [2*WORD_BITS-1:0] s_axis_tdata  = '0;      // [63:0] dominator, [127:64] bound
	logic                   m_axis_tvalid;
	logic                   m_axis_tready = 1'b0;
	logic [2*WORD_BITS-1:0] m_axis_tdata;            // [63:0] hit_count, [127:64] miss_count

	// predictor copy of the radix register; reset value is 2
	logic [RADIX_BITS-1:0] radix_now = RADIX_BITS'(2);
	count_pair_t           expected_counts[$];
	count_pair_t           front_counts;
	int                    error_count = 0;
	int unsigned           cycle_count = 0;
	int                    sink_stall  = 0;
	// when set, the matching side runs with no idle cycles
	bit                    src_steady  = 1'b0;
	bit                    sink_steady = 1'b0;

	digit_dominance_prefix_count_unit uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Digit DP over y = n-1, most significant digit first. Each place adds the dominated
	// choices below y's digit times the product of (m_i + 1) over the lower places; the
	// walk stops at the first digit of y above m's digit, else y itself counts once.
	function automatic count_pair_t predict_counts(word_t dom, word_t bnd,
			logic [RADIX_BITS-1:0] rdx);
		word_t       base, y, rest, acc, choices;
		word_t       ydig[WORD_BITS];
		word_t       mdig[WORD_BITS];
		word_t       weight[WORD_BITS];
		int          ylen, mlen, len, pos;
		bit          stopped;
		count_pair_t res;
		base = (rdx < 2) ? word_t'(2) : word_t'(rdx);    // radix 0 and 1 act as 2
		res.hit  = '0;
		res.miss = '0;
		if (bnd == '0)
			return res;
		y = bnd - 1;
		for (pos = 0; pos < WORD_BITS; pos++) begin
			ydig[pos] = '0;
			mdig[pos] = '0;
		end
		ydig[0] = y % base;
		rest = y / base;
		ylen = 1;
		while (rest != '0) begin
			ydig[ylen] = rest % base;
			rest = rest / base;
			ylen++;
		end
		mdig[0] = dom % base;
		rest = dom / base;
		mlen = 1;
		while (rest != '0) begin
			mdig[mlen] = rest % base;
			rest = rest / base;
			mlen++;
		end
		len = (ylen > mlen) ? ylen : mlen;
		weight[0] = 1;
		for (pos = 1; pos < len; pos++)
			weight[pos] = weight[pos-1] * (mdig[pos-1] + 1);
		acc = '0;
		stopped = 1'b0;
		for (pos = len - 1; pos >= 0 && !stopped; pos--) begin
			choices = (ydig[pos] < mdig[pos] + 1) ? ydig[pos] : mdig[pos] + 1;
			acc += choices * weight[pos];
			if (ydig[pos] > mdig[pos])
				stopped = 1'b1;
		end
		if (!stopped)
			acc += 1;
		res.miss = acc;
		res.hit  = bnd - acc;
		return res;
	endfunction

	// mostly short gaps, now and then a long one
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		else if (r < 85)
			return $urandom_range(1, 3);
		else if (r < 97)
			return $urandom_range(4, 12);
		else
			return $urandom_range(20, 60);
	endfunction

	// random value with a random number of leading zeros, so digit counts vary
	function automatic word_t rand_span();
		word_t v;
		v = {$urandom, $urandom};
		return v >> $urandom_range(0, WORD_BITS - 1);
	endfunction

	task automatic report_mismatch(string what, word_t got, word_t want);
		if (error_count < MAX_REPORTS)
			$display("MISMATCH %s: got %h, want %h (cycle %0d)", what, got, want, cycle_count);
		error_count++;
	endtask

	// Drives one word and holds it until taken. tvalid is only lowered ahead of a gap,
	// so back-to-back words never see a low and a high in the same step.
	task automatic send_word(word_t dom, word_t bnd);
		int gap;
		gap = src_steady ? 0 : pick_gap();
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {bnd, dom};
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		expected_counts.insert(expected_counts.size(), predict_counts(dom, bnd, radix_now));
	endtask

	// stop sending and let every pending result come back
	task automatic wait_idle();
		s_axis_tvalid <= 1'b0;
		while (expected_counts.size() != 0)
			@(posedge clk);
	endtask

	task automatic set_radix(logic [RADIX_BITS-1:0] value);
		wait_idle();
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we    <= 1'b0;
		radix_now = value;
	endtask

	// no config write yet: the reset radix of 2 must be in effect
	task automatic test_default_radix();
		send_word('0, '0);                        // zero bound
		send_word('1, '0);                        // zero bound, wide dominator
		send_word('0, 64'd1);
		send_word('0, '1);
		send_word('1, '1);                        // everything dominated
		send_word('1, 64'd1);
		send_word(64'd5, 64'd6);                  // y equals m
		send_word(64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5556);
		send_word(64'h8000_0000_0000_0000, 64'h8000_0000_0000_0001);
	endtask

	task automatic test_radix_below_two();
		set_radix(8'd0);
		send_word(64'h0123_4567_89AB_CDEF, 64'hFEDC_BA98_7654_3210);
		send_word('1, '1);
		set_radix(8'd1);
		send_word(64'h0123_4567_89AB_CDEF, 64'hFEDC_BA98_7654_3210);
		send_word(64'hFFFF_0000_FFFF_0000, 64'hFFFF_0000_FFFF_0001);
	endtask

	task automatic test_wide_radix();
		set_radix(8'd255);
		send_word('1, '1);
		send_word('0, '1);
		send_word(64'h00FE_00FE_00FE_00FE, 64'h00FE_00FE_00FE_00FF);
		send_word(64'd1, '0);
		set_radix(8'd3);
		send_word(64'd100, 64'd81);
		set_radix(8'd10);
		send_word(64'd1234, 64'd5679);            // stops at the top digit
		send_word(64'd1234, 64'd1240);            // stops at the lowest digit
		send_word(64'd1234, 64'd1235);
	endtask

	// Phases of random words, one radix per phase. About half of the words are built so that y's
	// digits stay at or under m's, which keeps the digit walk going deep.
	task automatic test_random_phases();
		logic [RADIX_BITS-1:0] plan[12];
		word_t                 dom, bnd, y, rest, pow, base;
		int                    kind, d, mdig, ydig;
		plan = '{8'd2, 8'd255, 8'd3, 8'd16, 8'd10, 8'd7, 8'd0, 8'd1, 8'd128,
			8'd2, 8'd2, 8'd2};
		for (int ph = 0; ph < 12; ph++) begin
			if (ph >= 9)
				plan[ph] = RADIX_BITS'($urandom_range(2, 255));
			set_radix(plan[ph]);
			base = (radix_now < 2) ? word_t'(2) : word_t'(radix_now);
			for (int i = 0; i < PHASE_WORDS; i++) begin
				if (i % 25 == 0) begin
					src_steady  = ($urandom_range(0, 3) == 0);
					sink_steady = ($urandom_range(0, 3) == 0);
				end
				kind = $urandom_range(0, 99);
				dom  = rand_span();
				bnd  = rand_span();
				if (kind < 15) begin
					dom = {$urandom, $urandom};
					bnd = {$urandom, $urandom};
				end else if (kind < 30) begin
					bnd = dom + 1;
				end else if (kind < 65) begin
					// y digit by digit under m, now and then one digit above
					rest = dom;
					pow  = 1;
					y    = '0;
					for (d = 0; d < WORD_BITS && rest != '0; d++) begin
						mdig = int'(rest % base);
						rest = rest / base;
						if ($urandom_range(0, 11) == 0)
							ydig = $urandom_range(0, int'(base) - 1);
						else
							ydig = $urandom_range(0, mdig);
						y   += word_t'(ydig) * pow;
						pow *= base;
					end
					bnd = y + 1;
				end else if (kind < 75) begin
					bnd = dom - word_t'($urandom_range(0, 1000)) + 1;
				end else if (kind < 85) begin
					dom = word_t'($urandom_range(0, 4095));
					bnd = word_t'($urandom_range(0, 4095));
				end else if (kind < 90) begin
					bnd = '0;
				end
				send_word(dom, bnd);
			end
		end
		src_steady  = 1'b0;
		sink_steady = 1'b0;
	endtask

	// Result checker and sink stalls. Values are sampled at the edge, before any
	// register update of that edge lands; tready changes by nonblocking assignment.
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (expected_counts.size() == 0) begin
					report_mismatch("result word with nothing pending",
						m_axis_tdata[WORD_BITS-1:0], '0);
				end else begin
					front_counts = expected_counts.pop_front();
					if (m_axis_tdata[WORD_BITS-1:0] !== front_counts.hit)
						report_mismatch("hit_count", m_axis_tdata[WORD_BITS-1:0],
							front_counts.hit);
					if (m_axis_tdata[2*WORD_BITS-1:WORD_BITS] !== front_counts.miss)
						report_mismatch("miss_count", m_axis_tdata[2*WORD_BITS-1:WORD_BITS],
							front_counts.miss);
				end
			end
			if (sink_stall > 0) begin
				m_axis_tready <= 1'b0;
				sink_stall--;
			end else begin
				m_axis_tready <= 1'b1;
				if (!sink_steady && $urandom_range(0, 3) == 0)
					sink_stall = pick_gap();
			end
		end
	end

	// run-away guard
	initial begin : watchdog
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Some tests failed");
		$finish;
	end

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_default_radix();
		test_radix_below_two();
		test_wide_radix();
		test_random_phases();
		wait_idle();
		// any stray result word would show up within one full digit walk
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (error_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

[sim.f]
hw/rtl/ddpc_pkg.sv
hw/rtl/ddpc_seq.sv
hw/rtl/ddpc_dp.sv
hw/rtl/digit_dominance_prefix_count_unit.sv
tb/digit_dominance_prefix_count_unit_tb.sv
